>>> rtl/rmst_pkg.sv
`default_nettype none
package rmst_pkg;

    localparam int LEAF_BITS  = 10;
    localparam int LEAVES     = 1 << LEAF_BITS;
    localparam int NODE_BITS  = LEAF_BITS + 1;
    localparam int NODES      = 2 * LEAVES;
    // width of the query walk's node bound, which reaches one more than the largest node index
    localparam int ADDR_BITS  = NODE_BITS + 1;
    localparam int VALUE_BITS = 48;
    localparam int POS_BITS   = 11;
    localparam int CNT_BITS   = (POS_BITS > LEAF_BITS + 1) ? POS_BITS : LEAF_BITS + 1;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = POS_BITS;
    localparam int IN_DATA_BITS  = ((3 * POS_BITS + VALUE_BITS + 7) / 8) * 8;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    localparam t_value EMPTY_VALUE = -VALUE_BITS'(64'sd1000010000);

    localparam logic [POS_BITS-1:0] COUNT_RESET = POS_BITS'(1024);

    localparam logic [CFG_IDX_BITS-1:0] REG_LEAF_COUNT = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_SIGN_MODE  = CFG_IDX_BITS'(1);

    typedef enum logic [1:0] {
        CMD_INIT   = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [POS_BITS-1:0] leaf_count;
        logic                sign_mode;
    } t_cfg;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [POS_BITS-1:0] position;
        t_value              value;
        logic [POS_BITS-1:0] range_lo;
        logic [POS_BITS-1:0] range_hi;
    } t_item;

    typedef struct packed {
        t_value max_value;
        logic   range_empty;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/range_max_segment_tree.sv
// Max segment tree over up to 1024 leaves, numbered from one, node values
// 48-bit signed, all nodes in one node memory with one read and one write
// port.
// Slave stream: tuser carries the command (init, update, query), tdata the
// position, value and inclusive query range. Master stream: one transfer per
// query with the maximum in tdata and the empty-range flag in tuser.
// Config channel: index 0 sets the leaf count, index 1 the init sign mode;
// write it only while the block is idle.
// Reset and init both sweep the node memory, one node per cycle, with
// s_axis_tready low; leaf i then holds -i or +i.
// Update: a read of the leaf, a write of the leaf with the larger of its
// old and new value, then per tree level a write of the parent while the
// next sibling is read. An update outside the leaf count changes nothing.
// Query: per tree level of the range walk, a step for each end of the range,
// each with at most one node read; the walk then closes and issues the result.
// The result sits in an output register; the next item is taken while it
// waits, and a later query holds in its last step until that register is
// free.
`default_nettype none
module range_max_segment_tree (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [rmst_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [rmst_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // position[10:0], value[58:11], range_lo[69:59], range_hi[80:70], zero pad
    input  wire logic [rmst_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]                         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // max_value[47:0]
    output logic [rmst_pkg::VALUE_BITS-1:0]         m_axis_tdata,
    // range_empty[0]
    output logic                                    m_axis_tuser
);

    localparam int P = rmst_pkg::POS_BITS;
    localparam int V = rmst_pkg::VALUE_BITS;

    rmst_pkg::t_cfg    r_cfg;
    rmst_pkg::t_item   item;
    rmst_pkg::t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leaf_count <= rmst_pkg::COUNT_RESET;
            r_cfg.sign_mode  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rmst_pkg::REG_LEAF_COUNT: r_cfg.leaf_count <= i_cfg_data[P-1:0];
                rmst_pkg::REG_SIGN_MODE:  r_cfg.sign_mode  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        item.cmd      = s_axis_tuser;
        item.position = s_axis_tdata[P-1:0];
        item.value    = rmst_pkg::t_value'(s_axis_tdata[P+V-1:P]);
        item.range_lo = s_axis_tdata[2*P+V-1:P+V];
        item.range_hi = s_axis_tdata[3*P+V-1:2*P+V];
    end

    rmst_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_item   (item),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = result.max_value;
    assign m_axis_tuser = result.range_empty;

    a_busy_after_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == rmst_pkg::CMD_QUERY)
        |=> !s_axis_tready)
        else $error("block took a new item right after a query");

    a_empty_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser
        |-> (m_axis_tdata == rmst_pkg::EMPTY_VALUE))
        else $error("empty range without the sentinel value");

    a_build_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("block not sweeping the node memory after reset");

    a_init_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == rmst_pkg::CMD_INIT)
        |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("item taken during the rebuild sweep");

endmodule
`default_nettype wire

>>> rtl/rmst_ram.sv
`default_nettype none
module rmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/rmst_engine.sv
`default_nettype none
module rmst_engine (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rmst_pkg::t_cfg   i_cfg,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire rmst_pkg::t_item  i_item,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output rmst_pkg::t_result     o_result
);

    typedef enum logic [2:0] {
        ST_BUILD,
        ST_IDLE,
        ST_ULEAF,
        ST_UUP,
        ST_QA,
        ST_QB,
        ST_QFIN
    } t_state;

    function automatic rmst_pkg::t_value vmax(input rmst_pkg::t_value a,
                                              input rmst_pkg::t_value b);
        return (a >= b) ? a : b;
    endfunction

    // Closed form of a freshly built node: leaf i holds -i or +i, so a node
    // holds minus its first leaf, or plus its last leaf.
    function automatic rmst_pkg::t_value build_value(
        input logic [rmst_pkg::NODE_BITS-1:0] idx,
        input logic                           mode
    );
        int                                  h;
        logic [rmst_pkg::NODE_BITS-1:0]      off;
        logic [rmst_pkg::LEAF_BITS:0]        first;
        logic [rmst_pkg::LEAF_BITS:0]        span;
        h = 0;
        for (int k = 0; k < rmst_pkg::NODE_BITS; k++) begin
            if (idx[k]) begin
                h = k;
            end
        end
        off   = idx & ~(rmst_pkg::NODE_BITS'(1) << h);
        first = (rmst_pkg::LEAF_BITS + 1)'(off << (rmst_pkg::LEAF_BITS - h));
        span  = (rmst_pkg::LEAF_BITS + 1)'(1) << (rmst_pkg::LEAF_BITS - h);
        if (idx == '0) begin
            return '0;
        end else if (mode) begin
            return rmst_pkg::t_value'(first + span);
        end else begin
            return ~rmst_pkg::t_value'(first);
        end
    endfunction

    t_state                            r_state, n_state;
    logic [rmst_pkg::NODE_BITS-1:0]    r_idx, n_idx;
    logic [rmst_pkg::NODE_BITS-1:0]    r_p, n_p;
    logic [rmst_pkg::ADDR_BITS-1:0]    r_a, n_a;
    logic [rmst_pkg::ADDR_BITS-1:0]    r_b, n_b;
    rmst_pkg::t_value                  r_val, n_val;
    rmst_pkg::t_value                  r_cur, n_cur;
    rmst_pkg::t_value                  r_best, n_best;
    logic                              r_empty, n_empty;
    logic                              r_pend, n_pend;
    logic                              r_out_valid, n_out_valid;
    rmst_pkg::t_result                 r_out, n_out;

    logic                              ram_we;
    logic [rmst_pkg::NODE_BITS-1:0]    ram_waddr;
    rmst_pkg::t_value                  ram_wdata;
    logic                              ram_re;
    logic [rmst_pkg::NODE_BITS-1:0]    ram_raddr;
    logic [rmst_pkg::VALUE_BITS-1:0]   ram_rdata;
    rmst_pkg::t_value                  rdata;

    logic [rmst_pkg::CNT_BITS-1:0]     active_n;
    logic [rmst_pkg::CNT_BITS-1:0]     pos_e;
    logic [rmst_pkg::CNT_BITS-1:0]     lo_c;
    logic [rmst_pkg::CNT_BITS-1:0]     hi_c;
    logic [rmst_pkg::CNT_BITS-1:0]     pos_m1;
    logic [rmst_pkg::CNT_BITS-1:0]     lo_m1;
    logic                              pos_ok;
    logic                              range_none;
    rmst_pkg::t_value                  folded;
    rmst_pkg::t_value                  merged;
    logic [rmst_pkg::ADDR_BITS-1:0]    b_m1;

    rmst_ram #(
        .WIDTH (rmst_pkg::VALUE_BITS),
        .DEPTH (rmst_pkg::NODES)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rdata = rmst_pkg::t_value'(ram_rdata);

    always_comb begin
        if (rmst_pkg::CNT_BITS'(i_cfg.leaf_count) > rmst_pkg::CNT_BITS'(rmst_pkg::LEAVES)) begin
            active_n = rmst_pkg::CNT_BITS'(rmst_pkg::LEAVES);
        end else begin
            active_n = rmst_pkg::CNT_BITS'(i_cfg.leaf_count);
        end
        pos_e      = rmst_pkg::CNT_BITS'(i_item.position);
        pos_ok     = (pos_e != '0) && (pos_e <= active_n);
        pos_m1     = pos_e - rmst_pkg::CNT_BITS'(1);
        lo_c       = (i_item.range_lo == '0) ? rmst_pkg::CNT_BITS'(1)
                                             : rmst_pkg::CNT_BITS'(i_item.range_lo);
        hi_c       = (rmst_pkg::CNT_BITS'(i_item.range_hi) > active_n)
                     ? active_n : rmst_pkg::CNT_BITS'(i_item.range_hi);
        range_none = lo_c > hi_c;
        lo_m1      = lo_c - rmst_pkg::CNT_BITS'(1);
        b_m1       = r_b - rmst_pkg::ADDR_BITS'(1);
        folded     = r_pend ? vmax(r_best, rdata) : r_best;
        merged     = '0;

        n_state     = r_state;
        n_idx       = r_idx;
        n_p         = r_p;
        n_a         = r_a;
        n_b         = r_b;
        n_val       = r_val;
        n_cur       = r_cur;
        n_best      = folded;
        n_empty     = r_empty;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;

        ram_we    = 1'b0;
        ram_waddr = r_p;
        ram_wdata = r_cur;
        ram_re    = 1'b0;
        ram_raddr = r_p;

        case (r_state)
            ST_BUILD: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = build_value(r_idx, i_cfg.sign_mode);
                n_idx     = r_idx + rmst_pkg::NODE_BITS'(1);
                if (r_idx == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_item.cmd)
                        rmst_pkg::CMD_INIT: begin
                            n_idx   = '0;
                            n_state = ST_BUILD;
                        end
                        rmst_pkg::CMD_UPDATE: begin
                            if (pos_ok) begin
                                n_p       = {1'b1, pos_m1[rmst_pkg::LEAF_BITS-1:0]};
                                ram_re    = 1'b1;
                                ram_raddr = {1'b1, pos_m1[rmst_pkg::LEAF_BITS-1:0]};
                                n_val     = i_item.value;
                                n_state   = ST_ULEAF;
                            end
                        end
                        rmst_pkg::CMD_QUERY: begin
                            n_best = rmst_pkg::EMPTY_VALUE;
                            if (range_none) begin
                                n_empty = 1'b1;
                                n_state = ST_QFIN;
                            end else begin
                                n_empty = 1'b0;
                                n_a     = {1'b0, 1'b1, lo_m1[rmst_pkg::LEAF_BITS-1:0]};
                                n_b     = rmst_pkg::ADDR_BITS'(rmst_pkg::LEAVES)
                                          + rmst_pkg::ADDR_BITS'(hi_c);
                                n_state = ST_QA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ULEAF: begin
                merged    = vmax(rdata, r_val);
                ram_we    = 1'b1;
                ram_waddr = r_p;
                ram_wdata = merged;
                n_cur     = merged;
                ram_re    = 1'b1;
                ram_raddr = r_p ^ rmst_pkg::NODE_BITS'(1);
                n_p       = r_p >> 1;
                n_state   = ST_UUP;
            end
            ST_UUP: begin
                // parent = max(child just written, sibling read last cycle)
                merged    = vmax(r_cur, rdata);
                ram_we    = 1'b1;
                ram_waddr = r_p;
                ram_wdata = merged;
                n_cur     = merged;
                if (r_p == rmst_pkg::NODE_BITS'(1)) begin
                    n_state = ST_IDLE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_p ^ rmst_pkg::NODE_BITS'(1);
                    n_p       = r_p >> 1;
                end
            end
            ST_QA: begin
                if (r_a >= r_b) begin
                    n_state = ST_QFIN;
                end else begin
                    if (r_a[0]) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_a[rmst_pkg::NODE_BITS-1:0];
                        n_pend    = 1'b1;
                        n_a       = r_a + rmst_pkg::ADDR_BITS'(1);
                    end
                    n_state = ST_QB;
                end
            end
            ST_QB: begin
                if (r_b[0]) begin
                    ram_re    = 1'b1;
                    ram_raddr = b_m1[rmst_pkg::NODE_BITS-1:0];
                    n_pend    = 1'b1;
                end
                // an odd b steps down first, which the shift absorbs
                n_a     = r_a >> 1;
                n_b     = r_b >> 1;
                n_state = ST_QA;
            end
            ST_QFIN: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.max_value   = r_best;
                    n_out.range_empty = r_empty;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_BUILD;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_p     <= n_p;
        r_a     <= n_a;
        r_b     <= n_b;
        r_val   <= n_val;
        r_cur   <= n_cur;
        r_best  <= n_best;
        r_empty <= n_empty;
        r_out   <= n_out;
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

>>> tb/tb.sv
module tb;
    import rmst_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam t_value     VALUE_MAX    = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam t_value     VALUE_MIN    = {1'b1, {(VALUE_BITS-1){1'b0}}};
    // init sweep plus margin; covers any update or init still running
    localparam int         SWEEP_CYCLES = NODES + 64;
    localparam int         HOLD_CYCLES  = 600;
    localparam int         CYCLE_LIMIT  = 1000000;

    // Leaf-level model of the tree: every inner node is the max of its leaves,
    // so a range max over the leaves gives what the tree walk returns.
    class tree_max_board;
        t_value      leaf_val [LEAVES];
        int unsigned leaf_count;
        bit          sign_mode;
        t_result     pending_max [$];
        int          errors, inits, updates, queries, empties, unknowns;

        function new();
            leaf_count = COUNT_RESET;
            sign_mode  = 1'b0;
            rebuild();
        endfunction

        function void rebuild();
            for (int i = 0; i < LEAVES; i++)
                leaf_val[i] = sign_mode ? t_value'(i + 1) : -t_value'(i + 1);
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_LEAF_COUNT)
                leaf_count = data;
            else if (idx == REG_SIGN_MODE)
                sign_mode = data[0];
        endfunction

        function void take_item(logic [1:0] cmd, logic [IN_DATA_BITS-1:0] data);
            logic [POS_BITS-1:0] pos, lo_raw, hi_raw;
            t_value              val, best;
            t_result             want;
            int                  lo, hi, n;
            pos    = data[POS_BITS-1:0];
            val    = data[POS_BITS +: VALUE_BITS];
            lo_raw = data[POS_BITS+VALUE_BITS +: POS_BITS];
            hi_raw = data[2*POS_BITS+VALUE_BITS +: POS_BITS];
            n      = (leaf_count > LEAVES) ? LEAVES : leaf_count;
            case (cmd)
                CMD_INIT: begin
                    inits++;
                    rebuild();
                end
                CMD_UPDATE: begin
                    updates++;
                    if (pos >= 1 && pos <= n && val > leaf_val[pos-1])
                        leaf_val[pos-1] = val;
                end
                CMD_QUERY: begin
                    queries++;
                    lo = (lo_raw < 1) ? 1 : lo_raw;
                    hi = (hi_raw > n) ? n : hi_raw;
                    if (lo > hi) begin
                        empties++;
                        want.max_value   = EMPTY_VALUE;
                        want.range_empty = 1'b1;
                    end else begin
                        best = leaf_val[lo-1];
                        for (int i = lo; i < hi; i++)
                            if (leaf_val[i] > best)
                                best = leaf_val[i];
                        want.max_value   = best;
                        want.range_empty = 1'b0;
                    end
                    pending_max.push_back(want);
                end
                default: unknowns++;
            endcase
        endfunction

        function void check_max(logic [VALUE_BITS-1:0] got_val, logic got_empty);
            t_result want;
            if (pending_max.size() == 0) begin
                $error("max_value: no query waiting, got %0d", $signed(got_val));
                errors++;
                return;
            end
            want = pending_max.pop_front();
            if (got_val !== want.max_value) begin
                $error("max_value: expected %0d, got %0d", want.max_value,
                       $signed(got_val));
                errors++;
            end
            if (got_empty !== want.range_empty) begin
                $error("range_empty: expected %0d, got %0d", want.range_empty, got_empty);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_valid   = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data    = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata  = '0;
    logic [1:0]                s_axis_tuser  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b1;
    logic [VALUE_BITS-1:0]     m_axis_tdata;
    logic                      m_axis_tuser;

    tree_max_board board;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  rx_hold        = 1'b0;
    int  cur_count      = LEAVES;
    int  settings       = 0;
    int  cycle_cnt      = 0;

    range_max_segment_tree DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // transfer monitor: all three channels sampled at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                board.write_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                board.take_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_max(m_axis_tdata, m_axis_tuser);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [POS_BITS-1:0] pos,
                             input t_value val, input logic [POS_BITS-1:0] lo,
                             input logic [POS_BITS-1:0] hi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_DATA_BITS'({hi, lo, val, pos});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // settle first so the monitor has logged the last transfer before the
    // wait for outstanding results
    task automatic quiesce(input int settle);
        s_axis_tvalid <= 1'b0;
        repeat (settle) @(posedge i_clk);
        while (board.pending_max.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic reconfigure(input int count, input bit sign);
        quiesce(SWEEP_CYCLES);
        write_reg(REG_LEAF_COUNT, CFG_DATA_BITS'(count));
        write_reg(REG_SIGN_MODE, CFG_DATA_BITS'(sign));
        i_cfg_valid <= 1'b0;
        cur_count = (count > LEAVES) ? LEAVES : count;
        settings++;
    endtask

    task automatic random_item(input bit query_only);
        logic [1:0]          cmd;
        logic [POS_BITS-1:0] pos, lo, hi, tmp;
        t_value              val;
        int                  r;
        r = query_only ? 99 : $urandom_range(99);
        if (r < 2)
            cmd = CMD_INIT;
        else if (r < 5)
            cmd = CMD_UNUSED;
        else if (r < 45)
            cmd = CMD_UPDATE;
        else
            cmd = CMD_QUERY;

        pos = POS_BITS'($urandom);
        if (cur_count > 0 && $urandom_range(99) < 85)
            pos = POS_BITS'($urandom_range(cur_count, 1));

        case ($urandom_range(3))
            0:       val = t_value'({$urandom, $urandom});
            1:       val = t_value'($urandom_range(4096)) - 2048;
            2:       val = $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
            default: val = t_value'($signed($urandom));
        endcase

        lo = POS_BITS'($urandom);
        hi = POS_BITS'($urandom);
        r  = $urandom_range(9);
        if (cur_count > 0 && r < 8) begin
            lo = POS_BITS'($urandom_range(cur_count, 1));
            hi = POS_BITS'($urandom_range(cur_count, lo));
        end else if (r == 8 && lo < hi) begin
            // reversed range
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        send_item(cmd, pos, val, lo, hi);
    endtask

    initial begin
        int cnt;
        bit sgn;
        board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state: 1024 leaves, leaf i = -i
        send_item(CMD_QUERY, 0, 0, 1, 1024);
        send_item(CMD_QUERY, 0, 0, 1024, 1024);
        send_item(CMD_QUERY, 0, 0, 5, 3);
        send_item(CMD_QUERY, 0, 0, 0, 0);
        send_item(CMD_QUERY, 0, 0, 0, 2047);
        send_item(CMD_QUERY, 0, 0, 2047, 2047);
        send_item(CMD_UPDATE, 0, VALUE_MAX, 0, 0);
        send_item(CMD_UPDATE, 2047, VALUE_MAX, 0, 0);
        send_item(CMD_UPDATE, 1, VALUE_MAX, 0, 0);
        send_item(CMD_UPDATE, 1024, VALUE_MIN, 0, 0);
        send_item(CMD_UPDATE, 512, 0, 0, 0);
        send_item(CMD_UNUSED, '1, '1, '1, '1);
        send_item(CMD_QUERY, 0, 0, 1, 1);
        send_item(CMD_QUERY, 0, 0, 2, 1024);
        send_item(CMD_INIT, 0, 0, 0, 0);
        send_item(CMD_QUERY, 0, 0, 1, 1024);

        // single leaf, positive init
        reconfigure(1, 1'b1);
        send_item(CMD_INIT, 0, 0, 0, 0);
        send_item(CMD_QUERY, 0, 0, 1, 1024);
        send_item(CMD_UPDATE, 2, 100, 0, 0);
        send_item(CMD_QUERY, 0, 0, 2, 2);

        // no leaves: nothing updates, every range is empty
        reconfigure(0, 1'b0);
        send_item(CMD_UPDATE, 1, 5, 0, 0);
        send_item(CMD_QUERY, 0, 0, 1, 1024);

        // count above the tree size; leaves still hold +i until init
        reconfigure(2047, 1'b0);
        send_item(CMD_QUERY, 0, 0, 1, 1024);
        send_item(CMD_INIT, 0, 0, 0, 0);
        send_item(CMD_QUERY, 0, 0, 1000, 1024);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       begin cnt = 1024; sgn = 1'b0; end
                1:       begin cnt = 8;    sgn = 1'b1; end
                2:       begin cnt = 1;    sgn = 1'b0; end
                3:       begin cnt = 2047; sgn = 1'b1; end
                4:       begin cnt = 37;   sgn = 1'b1; end
                5:       begin cnt = 1025; sgn = 1'b0; end
                6:       begin cnt = 0;    sgn = 1'b1; end
                default: begin cnt = 300;  sgn = 1'b0; end
            endcase
            reconfigure(cnt, sgn);
            send_idle_pct  = (ph % 4 == 1) ? 64 : (ph % 4 == 3) ? 32 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 64 : (ph % 4 == 3) ? 32 : 0;
            if ($urandom_range(1))
                send_item(CMD_INIT, 0, 0, 0, 0);
            if (ph == 0) begin
                // output held off while queries keep coming: input must stall
                fork
                    begin
                        @(negedge i_clk) rx_hold = 1'b1;
                        repeat (HOLD_CYCLES) @(negedge i_clk);
                        rx_hold = 1'b0;
                    end
                    repeat (40) random_item(1'b1);
                join
            end
            repeat (60) random_item(1'b0);
        end

        quiesce(64);
        $display("Covered %0d inits, %0d updates, %0d queries (%0d empty), %0d unknown cmds",
                 board.inits, board.updates, board.queries, board.empties, board.unknowns);
        $display("over %0d register settings, with sender gaps, output stalls and a long hold",
                 settings);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
